@@ src/hrsp_pkg.sv @@
package hrsp_pkg;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_START = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_BODY = 2'd0,
      KIND_HDRS = 2'd1,
      KIND_DONE = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_BODY = 2'd1,
      PH_FIN  = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      LM_START  = 4'd0,
      LM_PREFIX = 4'd1,
      LM_WAITSP = 4'd2,
      LM_NLEAD  = 4'd3,
      LM_NAME   = 4'd4,
      LM_NTAIL  = 4'd5,
      LM_VLEAD  = 4'd6,
      LM_VAL    = 4'd7,
      LM_VTAIL  = 4'd8,
      LM_NDONE  = 4'd9,
      LM_DEAD   = 4'd10
   } lm_type;

   typedef enum logic [1:0] {
      TG_NONE   = 2'd0,
      TG_STATUS = 2'd1,
      TG_CL     = 2'd2,
      TG_TE     = 2'd3
   } tg_type;

   typedef enum logic [2:0] {
      SZ_LEAD   = 3'd0,
      SZ_SIGNED = 3'd1,
      SZ_ZERO   = 3'd2,
      SZ_AFTERX = 3'd3,
      SZ_DIG    = 3'd4,
      SZ_DONE   = 3'd5
   } sz_type;

   typedef enum logic [2:0] {
      DC_SIZE  = 3'd0,
      DC_DATA  = 3'd1,
      DC_SKIP2 = 3'd2,
      DC_SKIP1 = 3'd3,
      DC_END   = 3'd4
   } dc_type;

   localparam int CL_LEN = 14;
   localparam int TE_LEN = 17;

   // one classified request passed from the front part to the back part
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] rx_byte;
      logic       is_lf;
      logic       is_cr;
      logic       is_ws;
      logic       is_dig;
      logic [3:0] dig;
      logic       hex_ok;
      logic [3:0] hex;
      logic [7:0] lower;
   } req_class_type;

   // one result
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  body_byte;
      logic [9:0]  status_code;
      logic [31:0] declared_length;
      logic        is_chunked;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] cl_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0: c = "c";   5'd1: c = "o";   5'd2: c = "n";   5'd3: c = "t";
         5'd4: c = "e";   5'd5: c = "n";   5'd6: c = "t";   5'd7: c = "-";
         5'd8: c = "l";   5'd9: c = "e";   5'd10: c = "n";  5'd11: c = "g";
         5'd12: c = "t";  5'd13: c = "h";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0: c = "t";   5'd1: c = "r";   5'd2: c = "a";   5'd3: c = "n";
         5'd4: c = "s";   5'd5: c = "f";   5'd6: c = "e";   5'd7: c = "r";
         5'd8: c = "-";   5'd9: c = "e";   5'd10: c = "n";  5'd11: c = "c";
         5'd12: c = "o";  5'd13: c = "d";  5'd14: c = "i";  5'd15: c = "n";
         5'd16: c = "g";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] chunked_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0: c = "c";  5'd1: c = "h";  5'd2: c = "u";  5'd3: c = "n";
         5'd4: c = "k";  5'd5: c = "e";  5'd6: c = "d";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0: c = "H";  5'd1: c = "T";  5'd2: c = "T";  5'd3: c = "P";
         5'd4: c = "/";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

@@ src/hrsp_front.sv @@
// classifies each request byte and holds it in a two-entry queue
module hrsp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_cmd,
   input  logic [7:0]             req_rx_byte,
   output logic                   q_valid,
   input  logic                   q_take,
   output hrsp_pkg::req_class_type q_data
);

   hrsp_pkg::req_class_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   hrsp_pkg::req_class_type cls;
   logic       push_ok, take_ok;
   logic [7:0] b;

   always_comb begin
      b = req_rx_byte;
      cls.cmd     = hrsp_pkg::cmd_type'(req_cmd);
      cls.rx_byte = b;
      cls.is_lf   = (b == 8'h0a);
      cls.is_cr   = (b == 8'h0d);
      cls.is_ws   = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
      cls.is_dig  = (b >= "0" && b <= "9");
      cls.dig     = 4'(b - "0");
      cls.lower   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      cls.hex_ok  = 1'b1;
      if (cls.is_dig) begin
         cls.hex = 4'(b - "0");
      end else if (cls.lower >= "a" && cls.lower <= "f") begin
         cls.hex = 4'(cls.lower - "a" + 8'd10);
      end else begin
         cls.hex    = 4'd0;
         cls.hex_ok = 1'b0;
      end
   end

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_data   = mem_ff[rd_ff];
   assign push_ok  = req_push && !req_full;
   assign take_ok  = q_take && q_valid;

   always_comb begin
      count_in = count_ff + 2'(push_ok) - 2'(take_ok);
      rd_in    = rd_ff ^ take_ok;
      wr_in    = wr_ff ^ push_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push_ok) begin
         mem_ff[wr_ff] <= cls;
      end
   end

endmodule

@@ src/hrsp_back.sv @@
// parse state machine; at most two results per request, then a result queue
module hrsp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [20:0]             body_limit,
   input  logic                    q_valid,
   output logic                    q_take,
   input  hrsp_pkg::req_class_type q_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output hrsp_pkg::rsp_type       rsp_head
);

   // state
   hrsp_pkg::phase_type phase_ff, phase_in;
   logic        held_cr_ff, held_cr_in;
   logic [15:0] line_len_ff, line_len_in;
   logic [3:0]  sub_ff, sub_in;
   logic [4:0]  pos_ff, pos_in;
   hrsp_pkg::tg_type tgt_ff, tgt_in;
   logic        neg_ff, neg_in;
   logic [31:0] acc_ff, acc_in;
   logic [9:0]  status_ff, status_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] remain_ff, remain_in;
   logic        chunked_ff, chunked_in;
   logic [20:0] raw_ff, raw_in;
   hrsp_pkg::dc_type dc_ff, dc_in;
   logic [31:0] left_ff, left_in;

   // output queue, four entries
   hrsp_pkg::rsp_type oq_ff [4];
   logic [2:0] ocnt_ff, ocnt_in;
   logic [1:0] ord_ff, owr_ff;

   logic        n_out;
   logic [1:0]  n_res;
   hrsp_pkg::kind_type k0, k1;
   logic [7:0]  b0;
   logic        fire, pop_ok;
   hrsp_pkg::rsp_type r0, r1;

   logic [35:0] dec_m;
   logic [35:0] hex_m;
   logic [31:0] acc_dec, acc_hex;
   logic        numeric;
   logic [7:0]  c, lc;
   logic        done;

   assign q_take = q_valid && (ocnt_ff <= 3'd2);
   assign fire   = q_take;
   assign pop_ok = rsp_pop && !rsp_empty;
   assign rsp_empty = (ocnt_ff == 3'd0);
   assign rsp_head  = oq_ff[ord_ff];

   // saturating accumulators: *10 as shift-add, *16 as shift
   always_comb begin
      dec_m = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 36'(q_data.dig);
      acc_dec = (dec_m > 36'h07fffffff) ? 32'h7fffffff : dec_m[31:0];
      hex_m = {acc_ff, q_data.hex};
      acc_hex = (hex_m[35:32] != 4'd0) ? 32'hffffffff : hex_m[31:0];
   end

   always_comb begin
      phase_in   = phase_ff;
      held_cr_in = held_cr_ff;
      line_len_in = line_len_ff;
      sub_in     = sub_ff;
      pos_in     = pos_ff;
      tgt_in     = tgt_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      status_in  = status_ff;
      len_in     = len_ff;
      remain_in  = remain_ff;
      chunked_in = chunked_ff;
      raw_in     = raw_ff;
      dc_in      = dc_ff;
      left_in    = left_ff;
      n_res      = 2'd0;
      n_out      = 1'b0;
      k0         = hrsp_pkg::KIND_BODY;
      k1         = hrsp_pkg::KIND_DONE;
      b0         = 8'd0;
      numeric    = 1'b0;
      done       = 1'b0;
      c          = q_data.rx_byte;
      lc         = q_data.lower;

      if (q_data.cmd == hrsp_pkg::CMD_START) begin
         phase_in = hrsp_pkg::PH_HEAD;
         held_cr_in = 1'b0; line_len_in = '0; sub_in = '0; pos_in = '0;
         tgt_in = hrsp_pkg::TG_NONE; neg_in = 1'b0; acc_in = '0;
         status_in = '0; len_in = '1; remain_in = '1; chunked_in = 1'b0;
         raw_in = '0; dc_in = hrsp_pkg::DC_SIZE; left_in = '0;
      end else if (q_data.cmd == hrsp_pkg::CMD_NONE || phase_ff == hrsp_pkg::PH_FIN) begin
         n_res = 2'd0;
      end else if (q_data.cmd == hrsp_pkg::CMD_CLOSE) begin
         n_res = 2'd1;
         k0 = (phase_ff == hrsp_pkg::PH_HEAD && status_ff == 10'd0) ?
              hrsp_pkg::KIND_ERR : hrsp_pkg::KIND_DONE;
         phase_in = hrsp_pkg::PH_FIN;
      end else if (phase_ff == hrsp_pkg::PH_HEAD) begin
         if (q_data.is_lf) begin
            if (line_len_ff == 16'd0 || (line_len_ff == 16'd1 && held_cr_ff)) begin
               phase_in = hrsp_pkg::PH_BODY;
               n_res = 2'd1;
               k0 = hrsp_pkg::KIND_HDRS;
            end else begin
               // commit the line
               numeric = sub_ff == hrsp_pkg::LM_VLEAD || sub_ff == hrsp_pkg::LM_VAL ||
                         sub_ff == hrsp_pkg::LM_NDONE;
               if (tgt_ff == hrsp_pkg::TG_STATUS && numeric) begin
                  status_in = neg_ff ? 10'd0 :
                              (acc_ff > 32'd999 ? 10'd999 : acc_ff[9:0]);
               end
               if (tgt_ff == hrsp_pkg::TG_CL && numeric) begin
                  len_in    = neg_ff ? 32'd0 - acc_ff : acc_ff;
                  remain_in = neg_ff ? 32'd0 - acc_ff : acc_ff;
               end
               if (tgt_ff == hrsp_pkg::TG_TE && pos_ff == 5'd7 &&
                   (sub_ff == hrsp_pkg::LM_VAL || sub_ff == hrsp_pkg::LM_VTAIL)) begin
                  chunked_in = 1'b1;
               end
            end
            held_cr_in = 1'b0; line_len_in = '0; sub_in = '0; pos_in = '0;
            tgt_in = hrsp_pkg::TG_NONE; neg_in = 1'b0; acc_in = '0;
         end else begin
            if (line_len_ff != 16'hffff) line_len_in = line_len_ff + 16'd1;
            held_cr_in = q_data.is_cr;
            case (sub_ff)
               hrsp_pkg::LM_START, hrsp_pkg::LM_NLEAD: begin
                  if (sub_ff == hrsp_pkg::LM_START && status_ff == 10'd0 && c == "H") begin
                     sub_in = hrsp_pkg::LM_PREFIX; pos_in = 5'd1;
                  end else if (q_data.is_ws) begin
                     sub_in = hrsp_pkg::LM_NLEAD;
                  end else if (lc == "c") begin
                     tgt_in = hrsp_pkg::TG_CL; pos_in = 5'd1; sub_in = hrsp_pkg::LM_NAME;
                  end else if (lc == "t") begin
                     tgt_in = hrsp_pkg::TG_TE; pos_in = 5'd1; sub_in = hrsp_pkg::LM_NAME;
                  end else begin
                     sub_in = hrsp_pkg::LM_DEAD;
                  end
               end
               hrsp_pkg::LM_PREFIX: begin
                  if (pos_ff < 5'd5 && c == hrsp_pkg::prefix_char(pos_ff)) begin
                     pos_in = pos_ff + 5'd1;
                     if (pos_ff == 5'd4) sub_in = hrsp_pkg::LM_WAITSP;
                  end else begin
                     sub_in = hrsp_pkg::LM_DEAD;
                  end
               end
               hrsp_pkg::LM_WAITSP: begin
                  if (c == " ") begin
                     sub_in = hrsp_pkg::LM_VLEAD; tgt_in = hrsp_pkg::TG_STATUS;
                     pos_in = 5'd0;
                  end
               end
               hrsp_pkg::LM_NAME, hrsp_pkg::LM_NTAIL: begin
                  if (c == ":") begin
                     if ((tgt_ff == hrsp_pkg::TG_CL && pos_ff == 5'(hrsp_pkg::CL_LEN)) ||
                         (tgt_ff == hrsp_pkg::TG_TE && pos_ff == 5'(hrsp_pkg::TE_LEN))) begin
                        sub_in = hrsp_pkg::LM_VLEAD; pos_in = 5'd0;
                     end else begin
                        sub_in = hrsp_pkg::LM_DEAD;
                     end
                  end else if (q_data.is_ws) begin
                     sub_in = hrsp_pkg::LM_NTAIL;
                  end else if (sub_ff == hrsp_pkg::LM_NAME &&
                               ((tgt_ff == hrsp_pkg::TG_CL &&
                                 pos_ff < 5'(hrsp_pkg::CL_LEN) &&
                                 lc == hrsp_pkg::cl_char(pos_ff)) ||
                                (tgt_ff != hrsp_pkg::TG_CL &&
                                 pos_ff < 5'(hrsp_pkg::TE_LEN) &&
                                 lc == hrsp_pkg::te_char(pos_ff)))) begin
                     pos_in = pos_ff + 5'd1;
                  end else begin
                     sub_in = hrsp_pkg::LM_DEAD;
                  end
               end
               hrsp_pkg::LM_VLEAD: begin
                  if (!q_data.is_ws) begin
                     if (tgt_ff == hrsp_pkg::TG_TE) begin
                        if (lc == "c") begin
                           pos_in = 5'd1; sub_in = hrsp_pkg::LM_VAL;
                        end else begin
                           sub_in = hrsp_pkg::LM_DEAD;
                        end
                     end else if (c == "+" || c == "-") begin
                        neg_in = (c == "-"); sub_in = hrsp_pkg::LM_VAL;
                     end else if (q_data.is_dig) begin
                        acc_in = acc_dec; sub_in = hrsp_pkg::LM_VAL;
                     end else begin
                        sub_in = hrsp_pkg::LM_NDONE;
                     end
                  end
               end
               hrsp_pkg::LM_VAL: begin
                  if (tgt_ff == hrsp_pkg::TG_TE) begin
                     if (q_data.is_ws) begin
                        sub_in = hrsp_pkg::LM_VTAIL;
                     end else if (pos_ff < 5'd7 && lc == hrsp_pkg::chunked_char(pos_ff)) begin
                        pos_in = pos_ff + 5'd1;
                     end else begin
                        sub_in = hrsp_pkg::LM_DEAD;
                     end
                  end else if (q_data.is_dig) begin
                     acc_in = acc_dec;
                  end else begin
                     sub_in = hrsp_pkg::LM_NDONE;
                  end
               end
               hrsp_pkg::LM_VTAIL: begin
                  if (!q_data.is_ws) sub_in = hrsp_pkg::LM_DEAD;
               end
               default: begin
               end
            endcase
         end
      end else begin
         // body phase
         raw_in = raw_ff + 21'd1;
         if (chunked_ff) begin
            case (dc_ff)
               hrsp_pkg::DC_SIZE: begin
                  if (q_data.is_lf && held_cr_ff) begin
                     if (neg_ff || acc_ff == 32'd0) begin
                        dc_in = hrsp_pkg::DC_END;
                     end else begin
                        left_in = acc_ff; dc_in = hrsp_pkg::DC_DATA;
                     end
                  end else begin
                     held_cr_in = q_data.is_cr;
                     case (sub_ff)
                        4'(hrsp_pkg::SZ_LEAD), 4'(hrsp_pkg::SZ_SIGNED): begin
                           if (sub_ff == 4'(hrsp_pkg::SZ_LEAD) && q_data.is_ws) begin
                              sub_in = sub_ff;
                           end else if (sub_ff == 4'(hrsp_pkg::SZ_LEAD) &&
                                        (c == "+" || c == "-")) begin
                              neg_in = (c == "-"); sub_in = 4'(hrsp_pkg::SZ_SIGNED);
                           end else if (c == "0") begin
                              sub_in = 4'(hrsp_pkg::SZ_ZERO);
                           end else if (q_data.hex_ok) begin
                              acc_in = acc_hex; sub_in = 4'(hrsp_pkg::SZ_DIG);
                           end else begin
                              sub_in = 4'(hrsp_pkg::SZ_DONE);
                           end
                        end
                        4'(hrsp_pkg::SZ_ZERO): begin
                           if (c == "x" || c == "X") begin
                              sub_in = 4'(hrsp_pkg::SZ_AFTERX);
                           end else if (q_data.hex_ok) begin
                              acc_in = acc_hex; sub_in = 4'(hrsp_pkg::SZ_DIG);
                           end else begin
                              sub_in = 4'(hrsp_pkg::SZ_DONE);
                           end
                        end
                        4'(hrsp_pkg::SZ_AFTERX), 4'(hrsp_pkg::SZ_DIG): begin
                           if (q_data.hex_ok) begin
                              acc_in = acc_hex; sub_in = 4'(hrsp_pkg::SZ_DIG);
                           end else begin
                              sub_in = 4'(hrsp_pkg::SZ_DONE);
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               hrsp_pkg::DC_DATA: begin
                  left_in = left_ff - 32'd1;
                  if (left_ff == 32'd1) dc_in = hrsp_pkg::DC_SKIP2;
                  n_out = 1'b1;
               end
               hrsp_pkg::DC_SKIP2: dc_in = hrsp_pkg::DC_SKIP1;
               hrsp_pkg::DC_SKIP1: begin
                  dc_in = hrsp_pkg::DC_SIZE;
                  held_cr_in = 1'b0; line_len_in = '0; sub_in = '0; pos_in = '0;
                  tgt_in = hrsp_pkg::TG_NONE; neg_in = 1'b0; acc_in = '0;
               end
               default: begin
               end
            endcase
         end else begin
            n_out = 1'b1;
            if (remain_ff != 32'd0 && !remain_ff[31]) begin
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) done = 1'b1;
            end
         end
         if (raw_in >= body_limit) done = 1'b1;
         b0 = c;
         k0 = n_out ? hrsp_pkg::KIND_BODY : hrsp_pkg::KIND_DONE;
         n_res = 2'(n_out) + 2'(done);
         if (done) phase_in = hrsp_pkg::PH_FIN;
         if (!n_out) b0 = 8'd0;
      end
   end

   // result fields follow the state after the step, as does status/length
   always_comb begin
      r0.kind = k0;
      r0.body_byte = (k0 == hrsp_pkg::KIND_BODY) ? b0 : 8'd0;
      r0.status_code = status_in;
      r0.declared_length = len_in;
      r0.is_chunked = chunked_in;
      r0.last = (n_res == 2'd1);
      r1.kind = k1;
      r1.body_byte = 8'd0;
      r1.status_code = status_in;
      r1.declared_length = len_in;
      r1.is_chunked = chunked_in;
      r1.last = 1'b1;
      ocnt_in = ocnt_ff - 3'(pop_ok) + (fire ? 3'(n_res) : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrsp_pkg::PH_HEAD;
         held_cr_ff <= 1'b0; line_len_ff <= '0; sub_ff <= '0; pos_ff <= '0;
         tgt_ff <= hrsp_pkg::TG_NONE; neg_ff <= 1'b0; acc_ff <= '0;
         status_ff <= '0; len_ff <= '1; remain_ff <= '1; chunked_ff <= 1'b0;
         raw_ff <= '0; dc_ff <= hrsp_pkg::DC_SIZE; left_ff <= '0;
         ocnt_ff <= '0; ord_ff <= '0; owr_ff <= '0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in; held_cr_ff <= held_cr_in; line_len_ff <= line_len_in;
            sub_ff <= sub_in; pos_ff <= pos_in; tgt_ff <= tgt_in; neg_ff <= neg_in;
            acc_ff <= acc_in; status_ff <= status_in; len_ff <= len_in;
            remain_ff <= remain_in; chunked_ff <= chunked_in; raw_ff <= raw_in;
            dc_ff <= dc_in; left_ff <= left_in;
            owr_ff <= owr_ff + n_res;
         end
         ocnt_ff <= ocnt_in;
         if (pop_ok) ord_ff <= ord_ff + 2'd1;
      end
      if (fire && n_res != 2'd0) oq_ff[owr_ff] <= r0;
      if (fire && n_res == 2'd2) oq_ff[owr_ff + 2'd1] <= r1;
   end

endmodule

@@ src/http_response_stream_parser.sv @@
// a request is held in the front queue and its results are then written into
// the result queue, from whose head they appear on the result ports
// throughput: one request per cycle unless req_full; the back state machine
// takes one per cycle while its four-entry result queue has two free places
// reset: synchronous, active high; clears parse state, both queues and sets
// body_limit to 1024
module http_response_stream_parser #(
   parameter int LimitReset = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic [9:0]  rsp_status_code,
   output logic signed [31:0] rsp_declared_length,
   output logic        rsp_is_chunked,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [20:0] csr_body_limit
);

   // body limit register, writable at any time the host chooses
   logic [20:0] limit_ff;
   logic        q_valid, q_take;
   hrsp_pkg::req_class_type q_data;
   hrsp_pkg::rsp_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 21'(LimitReset);
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_body_limit;
      end
   end

   // front: classify bytes into a small queue
   hrsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_cmd     (req_cmd),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_data      (q_data)
   );

   // back: parse state and result queue
   hrsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .body_limit (limit_ff),
      .q_valid    (q_valid),
      .q_take     (q_take),
      .q_data     (q_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_head   (head)
   );

   assign rsp_kind            = head.kind;
   assign rsp_body_byte       = head.body_byte;
   assign rsp_status_code     = head.status_code;
   assign rsp_declared_length = head.declared_length;
   assign rsp_is_chunked      = head.is_chunked;
   assign rsp_last            = head.last;

endmodule

@@ src/hrsp_checker.sv @@
module hrsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_body_byte,
   input logic [9:0] rsp_status_code
);

   // nothing can be waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty) else $error("results after reset");

   // the input side has room right after reset
   a_room_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_full) else $error("full after reset");

   // a non-body result carries a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != 2'd0) |-> rsp_body_byte == 8'd0)
      else $error("byte in non-body result");

   // status never above saturation
   a_status_sat: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status_code <= 10'd999) else $error("status too big");

   // a waiting result that is not taken holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result lost");

endmodule

bind http_response_stream_parser hrsp_checker u_hrsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_kind        (rsp_kind),
   .rsp_body_byte   (rsp_body_byte),
   .rsp_status_code (rsp_status_code)
);
